/* sv/pnn_pkg.sv */
// Shared types and constants for the periodic nearest-neighbour search block.
// Holds register indexes, axis codes and the controller/datapath command structs.
// No dependencies.
package pnn_pkg;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BOX_X   = 3'd0,
        REG_BOX_Y   = 3'd1,
        REG_BOX_Z   = 3'd2,
        REG_QUERY_X = 3'd3,
        REG_QUERY_Y = 3'd4,
        REG_QUERY_Z = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic  load_item;
        logic  fold;
        axis_t axis;
        logic  square;
        logic  accumulate;
        logic  update_min;
        logic  root_init;
        logic  root_step;
        logic  load_result;
    } pnn_cmd_t;

    typedef struct packed {
        logic last;
        logic out_full;
    } pnn_status_t;

endpackage

/* sv/pnn_if.sv */
// Valid/ready channel interfaces for candidates, results and register writes.
// Depends on pnn_pkg for the register index width.
interface pnn_cand_if #(
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 20
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] cand_x;
    logic [COORD_BITS-1:0] cand_y;
    logic [COORD_BITS-1:0] cand_z;
    logic [ID_BITS-1:0]    cand_id;
    logic                  last;

    modport source (output valid, cand_x, cand_y, cand_z, cand_id, last, input ready);
    modport sink   (input valid, cand_x, cand_y, cand_z, cand_id, last, output ready);
endinterface

interface pnn_result_if #(
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 20
);
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [ID_BITS-1:0]    best_id;
    logic [COORD_BITS-1:0] best_distance;

    modport source (output valid, found, best_id, best_distance, input ready);
    modport sink   (input valid, found, best_id, best_distance, output ready);
endinterface

interface pnn_cfg_if #(
    parameter int COORD_BITS = 24
);
    logic                              valid;
    logic                              ready;
    logic [pnn_pkg::CFG_INDEX_BITS-1:0] index;
    logic [COORD_BITS-1:0]             data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/pnn_regs.sv */
// Configuration register file: box sides and query point.
// Depends on pnn_pkg and pnn_cfg_if.
module pnn_regs
    import pnn_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pnn_cfg_if.sink               cfg,
    output logic [COORD_BITS-1:0] box_x,
    output logic [COORD_BITS-1:0] box_y,
    output logic [COORD_BITS-1:0] box_z,
    output logic [COORD_BITS-1:0] query_x,
    output logic [COORD_BITS-1:0] query_y,
    output logic [COORD_BITS-1:0] query_z
);

    logic [COORD_BITS-1:0] box_x_reg, box_y_reg, box_z_reg;
    logic [COORD_BITS-1:0] query_x_reg, query_y_reg, query_z_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg   <= '1;
            box_y_reg   <= '1;
            box_z_reg   <= '1;
            query_x_reg <= '0;
            query_y_reg <= '0;
            query_z_reg <= '0;
        end
        else if (cfg.valid)
        begin
            // drop writes to unknown indexes
            unique case (cfg.index)
                REG_BOX_X:   box_x_reg   <= cfg.data;
                REG_BOX_Y:   box_y_reg   <= cfg.data;
                REG_BOX_Z:   box_z_reg   <= cfg.data;
                REG_QUERY_X: query_x_reg <= cfg.data;
                REG_QUERY_Y: query_y_reg <= cfg.data;
                REG_QUERY_Z: query_z_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    assign box_x   = box_x_reg;
    assign box_y   = box_y_reg;
    assign box_z   = box_z_reg;
    assign query_x = query_x_reg;
    assign query_y = query_y_reg;
    assign query_z = query_z_reg;

endmodule

/* sv/pnn_ctrl.sv */
// Sequencer for the search: steps the datapath through fold, square and
// accumulate per axis, the minimum update, the square root and the result load.
// Depends on pnn_pkg.
module pnn_ctrl
    import pnn_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cand_valid,
    output logic        cand_ready,
    input  pnn_status_t status,
    output pnn_cmd_t    cmd
);

    localparam int CNT_BITS = $clog2(COORD_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(COORD_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_SQUARE,
        S_ACC,
        S_UPDATE,
        S_ROOT_INIT,
        S_ROOT,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    axis_t                 axis_reg, axis_next;
    logic [CNT_BITS-1:0]   step_reg, step_next;
    logic                  ready_reg;
    logic                  accept;

    assign accept     = cand_valid && ready_reg;
    assign cand_ready = ready_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_FOLD;
                    axis_next  = AXIS_X;
                end
            end
            S_FOLD:   state_next = S_SQUARE;
            S_SQUARE: state_next = S_ACC;
            S_ACC:
            begin
                unique case (axis_reg)
                    AXIS_X:  begin axis_next = AXIS_Y; state_next = S_FOLD; end
                    AXIS_Y:  begin axis_next = AXIS_Z; state_next = S_FOLD; end
                    default: state_next = S_UPDATE;
                endcase
            end
            S_UPDATE: state_next = status.last ? S_ROOT_INIT : S_IDLE;
            S_ROOT_INIT:
            begin
                state_next = S_ROOT;
                step_next  = '0;
            end
            S_ROOT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register can take the result
                if (!status.out_full)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= AXIS_X;
            step_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.axis        = axis_reg;
        cmd.load_item   = accept;
        cmd.fold        = (state_reg == S_FOLD);
        cmd.square      = (state_reg == S_SQUARE);
        cmd.accumulate  = (state_reg == S_ACC);
        cmd.update_min  = (state_reg == S_UPDATE);
        cmd.root_init   = (state_reg == S_ROOT_INIT);
        cmd.root_step   = (state_reg == S_ROOT);
        cmd.load_result = (state_reg == S_EMIT) && !status.out_full;
    end

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> state_reg == S_IDLE)
        else $error("candidate ready outside idle");

    a_accept_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !ready_reg && state_reg == S_FOLD)
        else $error("sequencer did not start after a request");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> !status.out_full)
        else $error("result loaded over a waiting result");

    a_root_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROOT && step_reg == LAST_STEP |=> state_reg == S_EMIT)
        else $error("square root overran its step count");
`endif

endmodule

/* sv/pnn_dp.sv */
// Datapath: minimum-image fold, shared squarer, saturating sum, running
// minimum, bit-per-cycle square root and the output register.
// Depends on pnn_pkg.
module pnn_dp
    import pnn_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pnn_cmd_t              cmd,
    output pnn_status_t           status,
    input  logic [COORD_BITS-1:0] box_x,
    input  logic [COORD_BITS-1:0] box_y,
    input  logic [COORD_BITS-1:0] box_z,
    input  logic [COORD_BITS-1:0] query_x,
    input  logic [COORD_BITS-1:0] query_y,
    input  logic [COORD_BITS-1:0] query_z,
    input  logic [COORD_BITS-1:0] cand_x,
    input  logic [COORD_BITS-1:0] cand_y,
    input  logic [COORD_BITS-1:0] cand_z,
    input  logic [ID_BITS-1:0]    cand_id,
    input  logic                  last,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  found,
    output logic [ID_BITS-1:0]    best_id,
    output logic [COORD_BITS-1:0] best_distance
);

    localparam int C  = COORD_BITS;
    localparam int SQ = 2 * COORD_BITS;
    localparam int SUM_BITS = SQ + 2;
    localparam logic [SUM_BITS-1:0] SUM_CAP = {2'b00, {SQ{1'b1}}};

    // item registers
    logic [C-1:0]        cx_reg, cy_reg, cz_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic                last_reg;

    // per-axis pipeline
    logic [C-1:0]        d_reg;
    logic [SQ-1:0]       prod_reg;
    logic [SUM_BITS-1:0] sum_reg;

    // running minimum
    logic [SQ-1:0]       min_sq_reg;
    logic [ID_BITS-1:0]  min_id_reg;
    logic                have_min_reg;

    // square root
    logic [SQ-1:0]       rad_reg;
    logic [C+1:0]        rem_reg;
    logic [C-1:0]        root_reg;

    // output register
    logic                res_valid_reg;
    logic                found_reg;
    logic [ID_BITS-1:0]  best_id_reg;
    logic [C-1:0]        best_dist_reg;

    logic [C-1:0]        q_sel, c_sel, box_sel;
    logic [C-1:0]        d_abs, d_fold;
    logic [C:0]          d_twice;
    logic [SQ-1:0]       sum_sat;
    logic                take_min;
    logic [C+1:0]        rem_shift, trial;
    logic                root_bit;

    always_comb
    begin
        unique case (cmd.axis)
            AXIS_X:  begin q_sel = query_x; c_sel = cx_reg; box_sel = box_x; end
            AXIS_Y:  begin q_sel = query_y; c_sel = cy_reg; box_sel = box_y; end
            default: begin q_sel = query_z; c_sel = cz_reg; box_sel = box_z; end
        endcase
        d_abs   = (q_sel >= c_sel) ? (q_sel - c_sel) : (c_sel - q_sel);
        d_twice = {d_abs, 1'b0};
        // fold past half the box onto the nearer periodic image
        if (d_twice > {1'b0, box_sel})
            d_fold = (box_sel >= d_abs) ? (box_sel - d_abs) : (d_abs - box_sel);
        else
            d_fold = d_abs;
    end

    assign sum_sat  = (sum_reg > SUM_CAP) ? SUM_CAP[SQ-1:0] : sum_reg[SQ-1:0];
    assign take_min = (sum_sat != '0) && (!have_min_reg || sum_sat < min_sq_reg);

    assign rem_shift = {rem_reg[C-1:0], rad_reg[SQ-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign root_bit  = (rem_shift >= trial);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cx_reg   <= cand_x;
            cy_reg   <= cand_y;
            cz_reg   <= cand_z;
            id_reg   <= cand_id;
            last_reg <= last;
        end
        if (cmd.fold)
            d_reg <= d_fold;
        if (cmd.square)
            prod_reg <= d_reg * d_reg;
        if (cmd.load_item)
            sum_reg <= '0;
        else if (cmd.accumulate)
            sum_reg <= sum_reg + {2'b00, prod_reg};
        if (cmd.root_init)
        begin
            rad_reg  <= min_sq_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[SQ-3:0], 2'b00};
            rem_reg  <= root_bit ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[C-2:0], root_bit};
        end
        if (cmd.load_result)
        begin
            found_reg     <= have_min_reg;
            best_id_reg   <= have_min_reg ? min_id_reg : '0;
            best_dist_reg <= have_min_reg ? root_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sq_reg    <= '1;
            min_id_reg    <= '0;
            have_min_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_result)
            begin
                // clear the minimum for the next search
                min_sq_reg   <= '1;
                min_id_reg   <= '0;
                have_min_reg <= 1'b0;
            end
            else if (cmd.update_min && take_min)
            begin
                min_sq_reg   <= sum_sat;
                min_id_reg   <= id_reg;
                have_min_reg <= 1'b1;
            end
            if (cmd.load_result)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    assign status.last     = last_reg;
    assign status.out_full = res_valid_reg && !res_ready;

    assign res_valid     = res_valid_reg;
    assign found         = found_reg;
    assign best_id       = best_id_reg;
    assign best_distance = best_dist_reg;

`ifndef SYNTHESIS
    a_min_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        have_min_reg |-> min_sq_reg != '0)
        else $error("kept minimum is zero");

    a_empty_min_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !have_min_reg |-> min_sq_reg == '1 && min_id_reg == '0)
        else $error("minimum not cleared while empty");

    a_result_clears_min: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> !have_min_reg && res_valid_reg)
        else $error("result load did not clear the search");
`endif

endmodule

/* sv/periodic_nearest_neighbor.sv */
// Periodic nearest-neighbour search, top level.
// A new candidate is taken only once the previous one is through: three axes of
// fold, square and add on one shared multiplier, then the minimum update.
// After the last candidate come the one-bit-per-cycle square root and the result
// load; the result waits in an output register.
// Reset clears the search and sets the box to all ones and the query to 0.
module periodic_nearest_neighbor
    import pnn_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    pnn_cand_if.sink      cand,
    pnn_result_if.source  res,
    pnn_cfg_if.sink       cfg
);

    logic [COORD_BITS-1:0] box_x, box_y, box_z;
    logic [COORD_BITS-1:0] query_x, query_y, query_z;
    pnn_cmd_t              cmd;
    pnn_status_t           status;

    pnn_regs #(
        .COORD_BITS(COORD_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .box_x   (box_x),
        .box_y   (box_y),
        .box_z   (box_z),
        .query_x (query_x),
        .query_y (query_y),
        .query_z (query_z)
    );

    pnn_ctrl #(
        .COORD_BITS(COORD_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand.valid),
        .cand_ready (cand.ready),
        .status     (status),
        .cmd        (cmd)
    );

    pnn_dp #(
        .COORD_BITS(COORD_BITS),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .box_x         (box_x),
        .box_y         (box_y),
        .box_z         (box_z),
        .query_x       (query_x),
        .query_y       (query_y),
        .query_z       (query_z),
        .cand_x        (cand.cand_x),
        .cand_y        (cand.cand_y),
        .cand_z        (cand.cand_z),
        .cand_id       (cand.cand_id),
        .last          (cand.last),
        .res_valid     (res.valid),
        .res_ready     (res.ready),
        .found         (res.found),
        .best_id       (res.best_id),
        .best_distance (res.best_distance)
    );

endmodule

/* bench/min_image_checker.sv */
`timescale 1ns / 100ps
// Watches the candidate, result and register channels of periodic_nearest_neighbor,
// predicts each search result under the minimum-image rule and compares it.
// Depends on pnn_pkg and the channel interfaces in pnn_if.sv.
module min_image_checker
    import pnn_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 20
) (
    input  logic  clk,
    input  logic  rst_n,
    pnn_cand_if   cand,
    pnn_result_if res,
    pnn_cfg_if    cfg,
    output int    mismatches,
    output int    open_searches
);

    localparam int SQ_BITS  = 2 * COORD_BITS;
    localparam int ACC_BITS = SQ_BITS + 2;

    typedef struct packed {
        logic                  found;
        logic [ID_BITS-1:0]    best_id;
        logic [COORD_BITS-1:0] best_distance;
    } nearest_t;

    nearest_t              nearest_q[$];
    logic [COORD_BITS-1:0] side [3];
    logic [COORD_BITS-1:0] centre [3];
    logic [SQ_BITS-1:0]    closest_sq;
    logic [ID_BITS-1:0]    closest_id;
    logic                  have_closest;

    function automatic logic [COORD_BITS-1:0] fold_delta(
        input logic [COORD_BITS-1:0] q,
        input logic [COORD_BITS-1:0] c,
        input logic [COORD_BITS-1:0] span
    );
        logic [COORD_BITS-1:0] d;
        d = (q >= c) ? q - c : c - q;
        // wrap to the nearer periodic image once past half the box
        if ({d, 1'b0} > {1'b0, span})
            d = (span >= d) ? span - d : d - span;
        return d;
    endfunction

    function automatic logic [SQ_BITS-1:0] separation_sq(
        input logic [COORD_BITS-1:0] cx,
        input logic [COORD_BITS-1:0] cy,
        input logic [COORD_BITS-1:0] cz
    );
        logic [ACC_BITS-1:0] dx, dy, dz, acc;
        dx = ACC_BITS'(fold_delta(centre[AXIS_X], cx, side[AXIS_X]));
        dy = ACC_BITS'(fold_delta(centre[AXIS_Y], cy, side[AXIS_Y]));
        dz = ACC_BITS'(fold_delta(centre[AXIS_Z], cz, side[AXIS_Z]));
        acc = dx * dx + dy * dy + dz * dz;
        // saturate at all ones
        if (acc[SQ_BITS+1:SQ_BITS] != 2'b00)
            return '1;
        return acc[SQ_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] floor_root(input logic [SQ_BITS-1:0] n);
        logic [COORD_BITS-1:0] r, t;
        logic [SQ_BITS-1:0]    t2;
        r = '0;
        for (int b = COORD_BITS - 1; b >= 0; b--)
        begin
            t = r;
            t[b] = 1'b1;
            t2 = SQ_BITS'(t);
            if (t2 * t2 <= n)
                r = t;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        nearest_t           got, want;
        logic [SQ_BITS-1:0] dist_sq;
        int                 errs;
        if (!rst_n)
        begin
            side[AXIS_X]   = '1;
            side[AXIS_Y]   = '1;
            side[AXIS_Z]   = '1;
            centre[AXIS_X] = '0;
            centre[AXIS_Y] = '0;
            centre[AXIS_Z] = '0;
            closest_sq     = '1;
            closest_id     = '0;
            have_closest   = 1'b0;
            nearest_q.delete();
            mismatches    <= 0;
            open_searches <= 0;
        end
        else
        begin
            errs = 0;
            if (res.valid && res.ready)
            begin
                got.found         = res.found;
                got.best_id       = res.best_id;
                got.best_distance = res.best_distance;
                if (nearest_q.size() == 0)
                begin
                    $display("%0t ns: result with no search pending: found %0d id %h dist %h",
                             $time, got.found, got.best_id, got.best_distance);
                    errs++;
                end
                else
                begin
                    want = nearest_q.pop_front();
                    if (got.found !== want.found)
                    begin
                        $display("%0t ns: found expected %0d, got %0d",
                                 $time, want.found, got.found);
                        errs++;
                    end
                    if (got.best_id !== want.best_id)
                    begin
                        $display("%0t ns: best_id expected %h, got %h",
                                 $time, want.best_id, got.best_id);
                        errs++;
                    end
                    if (got.best_distance !== want.best_distance)
                    begin
                        $display("%0t ns: best_distance expected %h, got %h",
                                 $time, want.best_distance, got.best_distance);
                        errs++;
                    end
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_BOX_X:   side[AXIS_X]   = cfg.data;
                    REG_BOX_Y:   side[AXIS_Y]   = cfg.data;
                    REG_BOX_Z:   side[AXIS_Z]   = cfg.data;
                    REG_QUERY_X: centre[AXIS_X] = cfg.data;
                    REG_QUERY_Y: centre[AXIS_Y] = cfg.data;
                    REG_QUERY_Z: centre[AXIS_Z] = cfg.data;
                    default: ;
                endcase
            end

            if (cand.valid && cand.ready)
            begin
                dist_sq = separation_sq(cand.cand_x, cand.cand_y, cand.cand_z);
                // zero distance never wins; ties keep the earlier candidate
                if (dist_sq != '0 && (!have_closest || dist_sq < closest_sq))
                begin
                    closest_sq   = dist_sq;
                    closest_id   = cand.cand_id;
                    have_closest = 1'b1;
                end
                if (cand.last)
                begin
                    want.found         = have_closest;
                    want.best_id       = have_closest ? closest_id : '0;
                    want.best_distance = have_closest ? floor_root(closest_sq) : '0;
                    nearest_q = {nearest_q, want};
                    closest_sq   = '1;
                    closest_id   = '0;
                    have_closest = 1'b0;
                end
            end

            mismatches    <= mismatches + errs;
            open_searches <= nearest_q.size();
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Top of the periodic_nearest_neighbor bench: clock, reset, request stimulus and verdict.
// Depends on pnn_pkg, pnn_if.sv, the block itself and min_image_checker.
module testbench;
    import pnn_pkg::*;

    localparam int COORD_BITS    = 24;
    localparam int ID_BITS       = 20;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int SEARCHES_PER_SETTING = 6;
    localparam longint LIMIT_NS  = 5_000_000;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [COORD_BITS-1:0]     COORD_MAX    = '1;
    localparam logic [ID_BITS-1:0]        ID_MAX       = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic hold_req;
    logic hold_active;
    int   send_idle;
    int   recv_idle;
    int   items_sent;
    int   searches_done;
    int   settings_done;
    int   mismatches;
    int   open_searches;

    logic [COORD_BITS-1:0] cur_box [3];
    logic [COORD_BITS-1:0] cur_query [3];

    pnn_cand_if   #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) cand ();
    pnn_result_if #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) res ();
    pnn_cfg_if    #(.COORD_BITS(COORD_BITS))                    cfg ();

    periodic_nearest_neighbor #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cand  (cand),
        .res   (res),
        .cfg   (cfg)
    );

    min_image_checker #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cand          (cand),
        .res           (res),
        .cfg           (cfg),
        .mismatches    (mismatches),
        .open_searches (open_searches)
    );

    always #5 clk = ~clk;

    initial
    begin
        #(LIMIT_NS);
        $display("[periodic_nearest_neighbor] ERROR");
        $finish;
    end

    // result acceptance; hold off entirely while a hold is active
    initial
    begin
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            res.ready <= !hold_active && ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        hold_active <= 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    task automatic send_cand(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y,
        input logic [COORD_BITS-1:0] z,
        input logic [ID_BITS-1:0]    id,
        input logic                  fin
    );
        while ($urandom_range(99) < send_idle)
        begin
            cand.valid <= 1'b0;
            @(posedge clk);
        end
        cand.valid   <= 1'b1;
        cand.cand_x  <= x;
        cand.cand_y  <= y;
        cand.cand_z  <= z;
        cand.cand_id <= id;
        cand.last    <= fin;
        @(posedge clk);
        while (!cand.ready) @(posedge clk);
        items_sent++;
        if (fin)
            searches_done++;
    endtask

    task automatic write_reg(
        input logic [CFG_INDEX_BITS-1:0] idx,
        input logic [COORD_BITS-1:0]     value
    );
        while ($urandom_range(99) < send_idle)
        begin
            cfg.valid <= 1'b0;
            @(posedge clk);
        end
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
    endtask

    // drop the candidate request, wait for every pending result, then let the block drain
    task automatic settle();
        cand.valid <= 1'b0;
        @(posedge clk);
        wait (open_searches == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_setting(
        input logic [COORD_BITS-1:0] bx,
        input logic [COORD_BITS-1:0] by,
        input logic [COORD_BITS-1:0] bz,
        input logic [COORD_BITS-1:0] qx,
        input logic [COORD_BITS-1:0] qy,
        input logic [COORD_BITS-1:0] qz
    );
        settle();
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        write_reg(REG_QUERY_X, qx);
        write_reg(REG_QUERY_Y, qy);
        write_reg(REG_QUERY_Z, qz);
        cfg.valid <= 1'b0;
        cur_box[AXIS_X]   = bx;
        cur_box[AXIS_Y]   = by;
        cur_box[AXIS_Z]   = bz;
        cur_query[AXIS_X] = qx;
        cur_query[AXIS_Y] = qy;
        cur_query[AXIS_Z] = qz;
        settings_done++;
    endtask

    function automatic logic [COORD_BITS-1:0] pick_side();
        unique case ($urandom_range(5))
            0: return COORD_MAX;
            1: return COORD_BITS'(1);
            2: return COORD_BITS'($urandom_range(2, 64));
            3: return COORD_BITS'($urandom_range(65, 65535));
            4: return COORD_BITS'($urandom_range(1, COORD_MAX));
            default: return COORD_BITS'($urandom_range(COORD_MAX - 15, COORD_MAX));
        endcase
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_query(input logic [COORD_BITS-1:0] span);
        if ($urandom_range(4) == 0 || span == '0)
            return COORD_BITS'($urandom);
        return COORD_BITS'($urandom % span);
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord(input axis_t a);
        logic [COORD_BITS-1:0] span, q;
        span = cur_box[a];
        q    = cur_query[a];
        unique case ($urandom_range(7))
            0: return q;
            1: return q + COORD_BITS'($urandom_range(3));
            2: return q - COORD_BITS'($urandom_range(3));
            3: return COORD_BITS'($urandom);
            4: return (span == '0) ? '0 : span - 1'b1;
            5: return '0;
            default: return (span == '0) ? COORD_BITS'($urandom) : COORD_BITS'($urandom % span);
        endcase
    endfunction

    task automatic random_search();
        int                    len;
        int                    kind;
        logic [COORD_BITS-1:0] tx, ty, tz;
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        tx = '0;
        ty = '0;
        tz = '0;
        for (int k = 0; k < len; k++)
        begin
            kind = $urandom_range(11);
            if (kind == 0)
            begin
                // candidate on the query point
                tx = cur_query[AXIS_X];
                ty = cur_query[AXIS_Y];
                tz = cur_query[AXIS_Z];
            end
            else if (kind != 1 || k == 0)
            begin
                tx = pick_coord(AXIS_X);
                ty = pick_coord(AXIS_Y);
                tz = pick_coord(AXIS_Z);
            end
            // otherwise repeat the previous point under a fresh id to force a tie
            send_cand(tx, ty, tz, ID_BITS'($urandom), k == len - 1);
        end
    endtask

    initial
    begin
        logic paused;
        cand.valid   <= 1'b0;
        cand.cand_x  <= '0;
        cand.cand_y  <= '0;
        cand.cand_z  <= '0;
        cand.cand_id <= '0;
        cand.last    <= 1'b0;
        cfg.valid    <= 1'b0;
        cfg.index    <= '0;
        cfg.data     <= '0;
        hold_req     <= 1'b0;
        send_idle    <= 7;
        recv_idle    <= 57;
        items_sent    = 0;
        searches_done = 0;
        settings_done = 1;
        paused        = 1'b0;
        cur_box[AXIS_X]   = COORD_MAX;
        cur_box[AXIS_Y]   = COORD_MAX;
        cur_box[AXIS_Z]   = COORD_MAX;
        cur_query[AXIS_X] = '0;
        cur_query[AXIS_Y] = '0;
        cur_query[AXIS_Z] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: lone candidate on the query gives nothing found
        send_cand('0, '0, '0, '0, 1'b1);
        // far corner folds to zero distance, then a unit step wins
        send_cand(COORD_MAX, COORD_MAX, COORD_MAX, ID_MAX, 1'b0);
        send_cand(COORD_BITS'(1), '0, '0, ID_BITS'(5), 1'b1);

        program_setting(24'd1000, 24'd1000, 24'd1000, 24'd100, 24'd900, 24'd500);
        send_cand(24'd600, 24'd400, 24'd0, ID_BITS'(1), 1'b0);     // exactly half the box
        send_cand(24'd900, 24'd100, 24'd500, ID_BITS'(2), 1'b0);   // wraps on two axes
        send_cand(24'd900, 24'd100, 24'd500, ID_BITS'(3), 1'b0);   // tie, earlier stays
        send_cand(24'd20000, 24'd900, 24'd500, ID_BITS'(4), 1'b0); // outside the box
        send_cand(COORD_MAX, '0, COORD_MAX, ID_MAX, 1'b0);
        send_cand(24'd100, 24'd900, 24'd500, ID_BITS'(6), 1'b1);   // zero distance

        // zero and unit sides; far corner saturates the sum
        program_setting('0, COORD_BITS'(1), '0, '0, '0, '0);
        send_cand(COORD_MAX, COORD_MAX, COORD_MAX, ID_BITS'(20'hABCDE), 1'b1);
        // writes to unused indexes must leave the setting alone
        settle();
        write_reg(REG_SPARE_LO, COORD_MAX);
        write_reg(REG_SPARE_HI, 24'h5A5A5A);
        cfg.valid <= 1'b0;
        send_cand('0, COORD_BITS'(1), '0, ID_BITS'(7), 1'b0);
        send_cand(COORD_BITS'(3), '0, '0, ID_BITS'(8), 1'b1);

        program_setting(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_cand('0, '0, '0, '0, 1'b0);
        send_cand(24'h7FFFFF, 24'h800000, 24'h7FFFFF, ID_BITS'(9), 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (searches_done % SEARCHES_PER_SETTING == 0)
                program_setting(pick_side(), pick_side(), pick_side(),
                                pick_query(cur_box[AXIS_X]), pick_query(cur_box[AXIS_Y]),
                                pick_query(cur_box[AXIS_Z]));
            if (items_sent < RANDOM_ITEMS / 3)
            begin
                send_idle <= 7;
                recv_idle <= 57;
            end
            else if (items_sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle <= 57;
                recv_idle <= 7;
            end
            else
            begin
                send_idle <= 0;
                recv_idle <= 0;
            end
            if (items_sent >= 150)
                hold_req <= 1'b1;
            if (items_sent >= 1000 && !paused)
            begin
                paused = 1'b1;
                settle();
            end
            // run one random search; its last candidate moves the search count on, so the setting cycle does not repeat
            random_search();
        end

        settle();
        $display("covered %0d random candidates and %0d searches under %0d register settings,",
                 items_sent, searches_done, settings_done);
        $display("with a %0d-cycle result hold and a pause for all results", HOLD_CYCLES);
        if (mismatches == 0)
            $display("[periodic_nearest_neighbor] OK");
        else
            $display("[periodic_nearest_neighbor] ERROR");
        $finish;
    end

endmodule
